[sv/rlefd_pkg.sv]
// Shared types and constants for the rle led frame decoder.
// No dependencies; imported by rlefd_frame_mod and rle_led_frame_decoder.
package rlefd_pkg;

  // field widths
  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 7;
  localparam int PIX_W     = 8;
  localparam int FRAME_W   = 16;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;
  localparam int PHASE_W   = 2;

  // encoding modes
  localparam logic [MODE_W-1:0] MODE_RAW    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RLE    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RLE565 = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEDS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = 2'd2;

  // byte phases within a record
  localparam logic [PHASE_W-1:0] PH_0 = 2'd0;
  localparam logic [PHASE_W-1:0] PH_1 = 2'd1;
  localparam logic [PHASE_W-1:0] PH_2 = 2'd2;
  localparam logic [PHASE_W-1:0] PH_3 = 2'd3;

  // reset values of the configuration registers
  localparam logic [PIX_W-1:0]   LEDS_RESET   = 8'd60;
  localparam logic [FRAME_W-1:0] FRAMES_RESET = 16'd1;

  // request to the frame index reduction unit
  typedef struct packed {
    logic               start;
    logic [FRAME_W-1:0] dividend;
    logic [FRAME_W-1:0] divisor;
  } mod_req_t;

  // status and result of the frame index reduction unit
  typedef struct packed {
    logic               busy;
    logic               done;
    logic [FRAME_W-1:0] remainder;
  } mod_res_t;

  // one run result
  typedef struct packed {
    logic [PIX_W-1:0]   start_pixel;
    logic [LEN_W-1:0]   run_pixels;
    logic [BYTE_W-1:0]  red;
    logic [BYTE_W-1:0]  green;
    logic [BYTE_W-1:0]  blue;
    logic               frame_end;
    logic [FRAME_W-1:0] frame_number;
    logic               animation_done;
  } run_item_t;

endpackage

[sv/rlefd_frame_mod.sv]
// Bit-serial remainder unit: frame index modulo frame count, one bit per cycle.
// Depends on rlefd_pkg (mod_req_t, mod_res_t).
module rlefd_frame_mod import rlefd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mod_req_t req,
  output mod_res_t res
);

  logic               busy;
  logic               done;
  logic [3:0]         step;
  logic [FRAME_W-1:0] dvd;
  logic [FRAME_W-1:0] dvs;
  logic [FRAME_W-1:0] rem;

  logic [FRAME_W:0]   rem_sh;
  logic [FRAME_W:0]   rem_diff;
  logic               rem_ge;
  logic [FRAME_W-1:0] rem_next;

  // one restoring step
  always_comb begin
    rem_sh   = {rem, dvd[FRAME_W-1]};
    rem_ge   = rem_sh >= {1'b0, dvs};
    rem_diff = rem_sh - {1'b0, dvs};
    rem_next = rem_ge ? rem_diff[FRAME_W-1:0] : rem_sh[FRAME_W-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= '0;
    end else if (busy) begin
      step <= step + 4'd1;
      if (step == 4'd15) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dvs <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[FRAME_W-2:0], 1'b0};
      rem <= rem_next;
    end
  end

  assign res.busy      = busy;
  assign res.done      = done;
  assign res.remainder = rem;

  // remainder is reduced once the unit finishes
  a_rem_reduced: assert property (@(posedge clk) disable iff (rst)
    done |-> rem < dvs)
    else $error("remainder not below divisor");

  // busy and done never overlap
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    !(busy && done))
    else $error("busy and done both set");

endmodule

[sv/rle_led_frame_decoder.sv]
// A result is registered on its last byte, in the skid entry if the output waits.
// Throughput: one byte per cycle unless stalled; a two-entry buffer keeps input moving.
// A write of frame_count stalls input while rlefd_frame_mod
// reduces the frame index one bit per cycle.
// Reset (rst, synchronous) clears phase, counters, buffers and loads register defaults.
module rle_led_frame_decoder import rlefd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_W-1:0]    data_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [PIX_W-1:0]     start_pixel,
  output logic [LEN_W-1:0]     run_pixels,
  output logic [BYTE_W-1:0]    red,
  output logic [BYTE_W-1:0]    green,
  output logic [BYTE_W-1:0]    blue,
  output logic                 frame_end,
  output logic [FRAME_W-1:0]   frame_number,
  output logic                 animation_done
);

  // configuration
  logic [MODE_W-1:0]  encoding_mode;
  logic [PIX_W-1:0]   led_count;
  logic [FRAME_W-1:0] frame_count;
  logic [FRAME_W-1:0] frame_count_eff;

  // decoder state
  logic [PHASE_W-1:0] byte_phase;
  logic [LEN_W-1:0]   held_length;
  logic [BYTE_W-1:0]  held_first;
  logic [BYTE_W-1:0]  held_second;
  logic [PIX_W-1:0]   pixel_count;
  logic [FRAME_W-1:0] frame_index;
  logic [FRAME_W-1:0] frame_red;

  // output buffer
  logic      out_full;
  run_item_t out_item;
  logic      skid_valid;
  run_item_t skid_item;

  mod_req_t mod_req;
  mod_res_t mod_res;

  logic               in_accept;
  logic               out_take;
  logic               emit;
  logic [PHASE_W-1:0] byte_phase_next;
  logic               load_length;
  logic               load_first;
  logic               load_second;
  logic [LEN_W-1:0]   run_len;
  logic [BYTE_W-1:0]  run_r;
  logic [BYTE_W-1:0]  run_g;
  logic [BYTE_W-1:0]  run_b;
  logic [PIX_W-1:0]   room;
  logic [LEN_W-1:0]   shown;
  logic [PIX_W:0]     pix_sum;
  logic               run_ends;
  logic [FRAME_W-1:0] frame_inc;
  logic [FRAME_W-1:0] frame_wrap;
  logic [FRAME_W-1:0] frame_after;
  run_item_t          new_item;

  assign in_accept       = in_valid && !in_stall;
  assign out_take        = out_full && !out_stall;
  assign in_stall        = skid_valid || mod_res.busy || mod_res.done;
  assign frame_count_eff = (frame_count == '0) ? FRAMES_RESET : frame_count;

  // record decode by mode and phase
  always_comb begin
    emit            = 1'b0;
    byte_phase_next = byte_phase;
    load_length     = 1'b0;
    load_first      = 1'b0;
    load_second     = 1'b0;
    run_len         = held_length;
    run_r           = held_first;
    run_g           = held_second;
    run_b           = data_byte;
    case (encoding_mode)
      MODE_RAW: begin
        run_len = 7'd1;
        if (byte_phase == PH_0) begin
          load_first      = 1'b1;
          byte_phase_next = PH_1;
        end else if (byte_phase == PH_1) begin
          load_second     = 1'b1;
          byte_phase_next = PH_2;
        end else begin
          emit = 1'b1;
        end
      end
      MODE_RLE: begin
        case (byte_phase)
          PH_0: begin
            load_length     = 1'b1;
            byte_phase_next = PH_1;
          end
          PH_1: begin
            load_first      = 1'b1;
            byte_phase_next = PH_2;
          end
          PH_2: begin
            load_second     = 1'b1;
            byte_phase_next = PH_3;
          end
          default: begin
            emit = 1'b1;
          end
        endcase
      end
      MODE_RLE565: begin
        run_r = {held_first[7:3], 3'b000};
        run_g = {held_first[2:0], data_byte[7:5], 2'b00};
        run_b = {data_byte[4:0], 3'b000};
        if (byte_phase == PH_0) begin
          load_length     = 1'b1;
          byte_phase_next = PH_1;
        end else if (byte_phase == PH_1) begin
          load_first      = 1'b1;
          byte_phase_next = PH_2;
        end else begin
          emit = 1'b1;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    if (emit) begin
      byte_phase_next = PH_0;
    end
  end

  // run placement, clipping and frame advance
  always_comb begin
    room        = (pixel_count < led_count) ? (led_count - pixel_count) : '0;
    shown       = ({1'b0, run_len} < room) ? run_len : room[LEN_W-1:0];
    pix_sum     = {1'b0, pixel_count} + {2'b00, run_len};
    run_ends    = pix_sum >= {1'b0, led_count};
    frame_inc   = frame_red + 16'd1;
    frame_wrap  = (frame_inc == frame_count_eff) ? '0 : frame_inc;
    frame_after = run_ends ? frame_wrap : frame_index;

    new_item.start_pixel    = pixel_count;
    new_item.run_pixels     = shown;
    new_item.red            = run_r;
    new_item.green          = run_g;
    new_item.blue           = run_b;
    new_item.frame_end      = run_ends;
    new_item.frame_number   = frame_after;
    new_item.animation_done = frame_after == '0;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      encoding_mode <= MODE_RAW;
      led_count     <= LEDS_RESET;
      frame_count   <= FRAMES_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_MODE:   encoding_mode <= cfg_data[MODE_W-1:0];
        CFG_LEDS:   led_count     <= cfg_data[PIX_W-1:0];
        CFG_FRAMES: frame_count   <= cfg_data;
        default:    ;
      endcase
    end
  end

  // frame index reduction after a frame count change
  always_comb begin
    mod_req.start    = cfg_write_en && (cfg_index == CFG_FRAMES);
    mod_req.dividend = frame_index;
    mod_req.divisor  = (cfg_data == '0) ? FRAMES_RESET : cfg_data;
  end

  rlefd_frame_mod u_frame_mod (
    .clk (clk),
    .rst (rst),
    .req (mod_req),
    .res (mod_res)
  );

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase  <= PH_0;
      held_length <= '0;
      held_first  <= '0;
      held_second <= '0;
      pixel_count <= '0;
      frame_index <= '0;
      frame_red   <= '0;
    end else begin
      if (mod_res.done) begin
        frame_red <= mod_res.remainder;
      end
      if (in_accept) begin
        byte_phase <= byte_phase_next;
        if (load_length) begin
          held_length <= data_byte[LEN_W-1:0];
        end
        if (load_first) begin
          held_first <= data_byte;
        end
        if (load_second) begin
          held_second <= data_byte;
        end
        if (emit) begin
          pixel_count <= run_ends ? '0 : pix_sum[PIX_W-1:0];
          if (run_ends) begin
            frame_index <= frame_wrap;
            frame_red   <= frame_wrap;
          end
        end
      end
    end
  end

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_full || out_take) begin
      if (skid_valid) begin
        out_full   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_full <= in_accept && emit;
      end
    end else if (in_accept && emit) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_full || out_take) begin
      if (skid_valid) begin
        out_item <= skid_item;
      end else if (in_accept && emit) begin
        out_item <= new_item;
      end
    end else if (in_accept && emit) begin
      skid_item <= new_item;
    end
  end

  assign out_valid      = out_full;
  assign start_pixel    = out_item.start_pixel;
  assign run_pixels     = out_item.run_pixels;
  assign red            = out_item.red;
  assign green          = out_item.green;
  assign blue           = out_item.blue;
  assign frame_end      = out_item.frame_end;
  assign frame_number   = out_item.frame_number;
  assign animation_done = out_item.animation_done;

  // reduced frame index stays below the frame count once settled
  a_frame_reduced: assert property (@(posedge clk) disable iff (rst)
    (!mod_res.busy && !mod_res.done) |-> frame_red < frame_count_eff)
    else $error("reduced frame index out of range");

  // skid entry only fills behind a waiting result
  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_full)
    else $error("skid entry valid with empty output register");

  // pixel count restarts after a frame end
  a_pixel_restart: assert property (@(posedge clk) disable iff (rst)
    (in_accept && emit && run_ends) |=> pixel_count == '0)
    else $error("pixel count not cleared at frame end");

  // a frame count write stops input for the reduction
  a_mod_stall: assert property (@(posedge clk) disable iff (rst)
    mod_req.start |=> in_stall)
    else $error("input not stalled during frame index reduction");

endmodule
